// ===== sv/scsp_pkg.sv =====
// ----------------------------------------------------------------------------
// scsp_pkg - shared types and constants
// Transfer structs, command codes and coil pattern lookup for the serial
// command stepper positioner.
// ----------------------------------------------------------------------------
package scsp_pkg;

   localparam logic [7:0] CHAR_STEPPER = 8'h41;
   localparam logic [7:0] CHAR_SERVO   = 8'h45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [9:0] SERVO_RESET  = 10'd145;
   localparam logic [1:0] DIGITS_LAST  = 2'd2;
   localparam logic [1:0] PHASE_LAST   = 2'd3;
   localparam logic       REQ_BYTE     = 1'b0;
   localparam logic       REQ_TICK     = 1'b1;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_STEPPER = 2'd1,
      CMD_SERVO   = 2'd2,
      CMD_DONE    = 2'd3
   } cmd_mode_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } scsp_req_type;

   typedef struct packed {
      logic [4:0] coil_pattern;
      logic [7:0] step_position;
      logic [9:0] servo_pulse;
      logic       moving;
   } scsp_rsp_type;

   // parser results seen by the stepper and the output stage
   typedef struct packed {
      logic [7:0] stepper_goal;
      logic [9:0] servo_setting;
   } scsp_cmd_type;

   // stepper results for the output stage
   typedef struct packed {
      logic [4:0] coil;
      logic [7:0] position;
      logic       busy;
   } scsp_step_type;

   function automatic logic [4:0] coil_lookup(input logic down, input logic [1:0] idx);
      logic [4:0] pat;
      pat = 5'd0;
      if (down) begin
         case (idx)
            2'd0:    pat = 5'b01100;
            2'd1:    pat = 5'b01010;
            2'd2:    pat = 5'b10010;
            default: pat = 5'b10100;
         endcase
      end else begin
         case (idx)
            2'd0:    pat = 5'b01100;
            2'd1:    pat = 5'b10100;
            2'd2:    pat = 5'b10010;
            default: pat = 5'b01010;
         endcase
      end
      return pat;
   endfunction

endpackage

// ===== sv/scsp_cmd_parser.sv =====
// ----------------------------------------------------------------------------
// scsp_cmd_parser - serial command decoder
// Collects a command letter and three decimal digits into the stepper goal
// or the servo setting.
// ----------------------------------------------------------------------------
module scsp_cmd_parser
   import scsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_en,
   input  logic [7:0]   rx_byte,
   output scsp_cmd_type cmd_cur,
   output scsp_cmd_type cmd_next
);

   cmd_mode_type mode_ff, mode_in;
   logic [1:0]   count_ff, count_in;
   logic [9:0]   value_ff, value_in;
   logic [7:0]   goal_ff, goal_in;
   logic [9:0]   servo_ff, servo_in;

   logic         is_digit;
   logic [12:0]  value_x10;
   logic [9:0]   value_acc;

   assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign value_x10 = {value_ff, 3'b000} + {2'b00, value_ff, 1'b0};
   assign value_acc = value_x10[9:0] + {6'd0, rx_byte[3:0]};

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      value_in = value_ff;
      goal_in  = goal_ff;
      servo_in = servo_ff;
      if (byte_en) begin
         if (rx_byte == CHAR_STEPPER || rx_byte == CHAR_SERVO) begin
            mode_in  = (rx_byte == CHAR_STEPPER) ? CMD_STEPPER : CMD_SERVO;
            count_in = 2'd0;
            value_in = 10'd0;
         end else if (is_digit) begin
            unique case (mode_ff)
               CMD_STEPPER, CMD_SERVO: begin
                  if (count_ff == DIGITS_LAST) begin
                     if (mode_ff == CMD_STEPPER) begin
                        goal_in = value_acc[9:2];
                     end else begin
                        servo_in = value_acc;
                     end
                     mode_in  = CMD_DONE;
                     count_in = 2'd0;
                     value_in = 10'd0;
                  end else begin
                     count_in = count_ff + 2'd1;
                     value_in = value_acc;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= CMD_NONE;
         count_ff <= 2'd0;
         value_ff <= 10'd0;
         goal_ff  <= 8'd0;
         servo_ff <= SERVO_RESET;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         value_ff <= value_in;
         goal_ff  <= goal_in;
         servo_ff <= servo_in;
      end
   end

   assign cmd_cur.stepper_goal   = goal_ff;
   assign cmd_cur.servo_setting  = servo_ff;
   assign cmd_next.stepper_goal  = goal_in;
   assign cmd_next.servo_setting = servo_in;

endmodule

// ===== sv/scsp_stepper.sv =====
// ----------------------------------------------------------------------------
// scsp_stepper - stepper move sequencer
// Starts moves toward the goal, walks the four coil phases per step and
// tracks the position.
// ----------------------------------------------------------------------------
module scsp_stepper
   import scsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          tick_en,
   input  logic          byte_en,
   input  logic [7:0]    stepper_goal,
   output scsp_step_type step_next
);

   logic [7:0] pos_ff, pos_in;
   logic [7:0] target_ff, target_in;
   logic [1:0] phase_ff, phase_in;
   logic       busy_ff, busy_in;
   logic       down_ff, down_in;
   logic [4:0] coil;

   logic [7:0] tgt_use;
   logic       down_use;
   logic [1:0] phase_use;
   logic [7:0] pos_step;

   assign tgt_use   = busy_ff ? target_ff : stepper_goal;
   assign down_use  = busy_ff ? down_ff : (stepper_goal < pos_ff);
   assign phase_use = busy_ff ? phase_ff : 2'd0;
   assign pos_step  = down_use ? (pos_ff - 8'd1) : (pos_ff + 8'd1);

   always_comb begin
      pos_in    = pos_ff;
      target_in = target_ff;
      phase_in  = phase_ff;
      busy_in   = busy_ff;
      down_in   = down_ff;
      coil      = 5'd0;
      if (tick_en) begin
         if (busy_ff || (stepper_goal != pos_ff)) begin
            target_in = tgt_use;
            down_in   = down_use;
            coil      = coil_lookup(down_use, phase_use);
            phase_in  = phase_use + 2'd1;
            busy_in   = 1'b1;
            if (phase_use == PHASE_LAST) begin
               pos_in  = pos_step;
               busy_in = (pos_step != tgt_use);
            end
         end
      end else if (byte_en && busy_ff) begin
         coil = coil_lookup(down_ff, phase_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 8'd0;
         target_ff <= 8'd0;
         phase_ff  <= 2'd0;
         busy_ff   <= 1'b0;
         down_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         target_ff <= target_in;
         phase_ff  <= phase_in;
         busy_ff   <= busy_in;
         down_ff   <= down_in;
      end
   end

   assign step_next.coil     = coil;
   assign step_next.position = pos_in;
   assign step_next.busy     = busy_in;

endmodule

// ===== sv/serial_command_stepper_positioner.sv =====
// ----------------------------------------------------------------------------
// serial_command_stepper_positioner - serial commanded stepper and servo
// response: registered, valid in the cycle after the request transfer
// throughput: one item per cycle while responses are taken, none while one stalls
// the response register frees when rsp_ready is high, so req_ready follows it
// reset: no command open, goal and position 0, motor idle, servo setting 145
// ----------------------------------------------------------------------------
module serial_command_stepper_positioner
   import scsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  scsp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output scsp_rsp_type rsp_data
);

   logic          rsp_valid_ff, rsp_valid_in;
   scsp_rsp_type  rsp_data_ff, rsp_data_in;
   logic          req_fire;
   logic          byte_en;
   logic          tick_en;
   scsp_cmd_type  cmd_cur;
   scsp_cmd_type  cmd_next;
   scsp_step_type step_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign byte_en   = req_fire && (req_data.req_type == REQ_BYTE);
   assign tick_en   = req_fire && (req_data.req_type == REQ_TICK);

   scsp_cmd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .byte_en  (byte_en),
      .rx_byte  (req_data.rx_byte),
      .cmd_cur  (cmd_cur),
      .cmd_next (cmd_next)
   );

   scsp_stepper u_stepper (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (tick_en),
      .byte_en      (byte_en),
      .stepper_goal (cmd_cur.stepper_goal),
      .step_next    (step_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.coil_pattern  = step_next.coil;
         rsp_data_in.step_position = step_next.position;
         rsp_data_in.servo_pulse   = cmd_next.servo_setting;
         rsp_data_in.moving        = step_next.busy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no new request while the response register is full and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   // an active move always drives a coil pattern
   a_moving_coil: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.moving) |-> (rsp_data_ff.coil_pattern != 5'd0))
      else $error("moving with coils off");

   // position stays within the reachable goal range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.step_position <= 8'd249))
      else $error("step position out of range");

   // servo setting never exceeds three digits
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.servo_pulse <= 10'd999))
      else $error("servo setting out of range");

endmodule

// ===== tb/sv/tb_serial_command_stepper_positioner.sv =====
// ----------------------------------------------------------------------------
// tb_serial_command_stepper_positioner - self-checking bench for the positioner
// A queue of serial bytes and phase ticks feeds a valid/ready driver. Every
// accepted transfer steps a local copy of the command parser and motor, whose
// expected response is checked field by field against the response channel.
// Both sides idle at random, and the receiver once holds off long enough for
// the block to stall its input.
// ----------------------------------------------------------------------------
module tb_serial_command_stepper_positioner;
   import scsp_pkg::*;

   localparam logic [3:0][4:0] COIL_DOWN = {5'h14, 5'h12, 5'h0A, 5'h0C};
   localparam logic [3:0][4:0] COIL_UP   = {5'h0A, 5'h12, 5'h14, 5'h0C};
   localparam int unsigned     RANDOM_ITEMS = 1650;
   localparam int unsigned     GOAL_MAX     = 249;
   localparam int unsigned     MAX_REPORTS  = 100;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   scsp_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   scsp_rsp_type rsp_data;

   scsp_req_type pending_req_q[$];
   scsp_rsp_type expected_rsp_q[$];
   scsp_rsp_type want_rsp;

   int unsigned  error_count    = 0;
   int unsigned  accepted_count = 0;
   int unsigned  checked_count  = 0;
   int unsigned  send_idle      = 0;
   int unsigned  rx_stall       = 0;
   bit           sender_calm    = 1'b0;
   bit           receiver_calm  = 1'b0;
   logic         long_hold      = 1'b0;

   // local copy of parser and motor state
   cmd_mode_type cmd_state;
   logic [1:0]   digits_seen;
   logic [9:0]   digits_acc;
   logic [7:0]   goal_steps;
   logic [9:0]   servo_value;
   logic [7:0]   position_steps;
   logic [7:0]   target_steps;
   logic [1:0]   phase_idx;
   logic         motor_busy;
   logic         motor_down;

   serial_command_stepper_positioner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [4:0] coil_at(input logic [1:0] idx);
      return motor_down ? COIL_DOWN[idx] : COIL_UP[idx];
   endfunction

   function automatic scsp_rsp_type advance_positioner(input scsp_req_type item);
      scsp_rsp_type res;
      logic [4:0]   coil;
      logic [7:0]   b;
      coil = '0;
      b = item.rx_byte;
      if (item.req_type == REQ_TICK) begin
         if (!motor_busy && goal_steps != position_steps) begin
            motor_busy   = 1'b1;
            target_steps = goal_steps;
            motor_down   = goal_steps < position_steps;
            phase_idx    = 2'd0;
         end
         if (motor_busy) begin
            coil = coil_at(phase_idx);
            if (phase_idx == PHASE_LAST) begin
               position_steps = motor_down ? position_steps - 8'd1 : position_steps + 8'd1;
               if (position_steps == target_steps) motor_busy = 1'b0;
            end
            phase_idx = phase_idx + 2'd1;
         end
      end else begin
         if (b == CHAR_STEPPER || b == CHAR_SERVO) begin
            if (b == CHAR_STEPPER) cmd_state = CMD_STEPPER;
            else cmd_state = CMD_SERVO;
            digits_seen = '0;
            digits_acc  = '0;
         end else if (b >= CHAR_ZERO && b <= CHAR_NINE &&
                      (cmd_state == CMD_STEPPER || cmd_state == CMD_SERVO)) begin
            digits_acc = 10'(digits_acc * 10 + (b - CHAR_ZERO));
            if (digits_seen == DIGITS_LAST) begin
               if (cmd_state == CMD_STEPPER) goal_steps = 8'(digits_acc / 4);
               else servo_value = digits_acc;
               cmd_state   = CMD_DONE;
               digits_seen = '0;
               digits_acc  = '0;
            end else begin
               digits_seen = digits_seen + 2'd1;
            end
         end
         // coils hold the last pattern while a move is under way
         if (motor_busy) coil = coil_at(phase_idx - 2'd1);
      end
      res.coil_pattern  = coil;
      res.step_position = position_steps;
      res.servo_pulse   = servo_value;
      res.moving        = motor_busy;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch at response %0d: %s got %0d expected %0d",
                  checked_count, what, got, want);
   endtask

   function automatic int unsigned pick_idle();
      if ($urandom_range(0, 99) < 8) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      scsp_req_type item;
      item.req_type = REQ_BYTE;
      item.rx_byte  = b;
      pending_req_q.push_back(item);
   endtask

   task automatic push_tick();
      scsp_req_type item;
      item.req_type = REQ_TICK;
      item.rx_byte  = 8'($urandom_range(0, 255));
      pending_req_q.push_back(item);
   endtask

   task automatic push_digit(input int unsigned d);
      push_byte(CHAR_ZERO + 8'(d));
   endtask

   task automatic push_command(input logic [7:0] letter, input int unsigned value);
      push_byte(letter);
      push_digit(value / 100);
      push_digit((value / 10) % 10);
      push_digit(value % 10);
   endtask

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == CHAR_STEPPER || b == CHAR_SERVO || (b >= CHAR_ZERO && b <= CHAR_NINE))
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(advance_positioner(req_data));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle <= send_idle - 1;
               req_valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
               req_data  <= pending_req_q.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 99) < 2) sender_calm <= ~sender_calm;
               if (!sender_calm && $urandom_range(0, 99) < 30) send_idle <= pick_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("transfer with nothing pending", 1, 0);
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               if (rsp_data.coil_pattern !== want_rsp.coil_pattern)
                  report_mismatch("coil_pattern", rsp_data.coil_pattern,
                                  want_rsp.coil_pattern);
               if (rsp_data.step_position !== want_rsp.step_position)
                  report_mismatch("step_position", rsp_data.step_position,
                                  want_rsp.step_position);
               if (rsp_data.servo_pulse !== want_rsp.servo_pulse)
                  report_mismatch("servo_pulse", rsp_data.servo_pulse,
                                  want_rsp.servo_pulse);
               if (rsp_data.moving !== want_rsp.moving)
                  report_mismatch("moving", rsp_data.moving, want_rsp.moving);
            end
            checked_count++;
         end
         if ($urandom_range(0, 99) < 1) receiver_calm <= ~receiver_calm;
         if (long_hold) begin
            rsp_ready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall  <= rx_stall - 1;
            rsp_ready <= 1'b0;
         end else if (!receiver_calm && $urandom_range(0, 99) < 20) begin
            rx_stall  <= pick_idle() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up into the input
   initial begin
      while (reset || accepted_count < 400) @(posedge clock);
      long_hold <= 1'b1;
      repeat (80) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned stim_count;
      int unsigned pick;
      int unsigned value;
      int unsigned n;
      int unsigned total_items;
      int          goal_hint;
      int          lo;
      int          hi;

      cmd_state      = CMD_NONE;
      digits_seen    = '0;
      digits_acc     = '0;
      goal_steps     = '0;
      servo_value    = SERVO_RESET;
      position_steps = '0;
      target_steps   = '0;
      phase_idx      = '0;
      motor_busy     = 1'b0;
      motor_down     = 1'b0;

      // directed: idle tick, stray bytes, servo maximum, restart, ignored bytes
      push_tick();
      push_byte(8'h00);
      push_byte(8'hFF);
      push_digit(5);
      push_command(CHAR_SERVO, 999);
      push_digit(3);
      push_byte(CHAR_SERVO);
      push_digit(0);
      push_byte(CHAR_STEPPER);
      push_digit(0);
      push_byte(CHAR_ZERO - 8'd1);
      push_byte(CHAR_NINE + 8'd1);
      push_digit(0);
      push_digit(4);
      repeat (4) push_tick();
      push_command(CHAR_STEPPER, 0);

      // random: mostly well formed commands and tick bursts
      stim_count = 0;
      goal_hint  = 1;
      while (stim_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            if ($urandom_range(0, 1) == 0) begin
               if ($urandom_range(0, 99) < 5) begin
                  value = $urandom_range(0, 999);
               end else begin
                  lo = (goal_hint > 50) ? goal_hint - 50 : 0;
                  hi = (goal_hint + 50 < GOAL_MAX) ? goal_hint + 50 : GOAL_MAX;
                  value = $urandom_range(hi, lo) * 4 + $urandom_range(0, 3);
               end
               goal_hint = value / 4;
               push_command(CHAR_STEPPER, value);
            end else begin
               push_command(CHAR_SERVO, $urandom_range(0, 999));
            end
            if ($urandom_range(0, 99) < 15) push_byte(noise_byte());
            stim_count += 4;
         end else if (pick < 85) begin
            n = $urandom_range(1, 24);
            repeat (n) push_tick();
            stim_count += n;
         end else if (pick < 93) begin
            push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 97) begin
            // broken command, cut short
            push_byte($urandom_range(0, 1) ? CHAR_STEPPER : CHAR_SERVO);
            n = $urandom_range(0, 2);
            repeat (n) push_digit($urandom_range(0, 9));
            stim_count += n + 1;
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) push_digit($urandom_range(0, 9));
            stim_count += n;
         end
      end
      total_items = pending_req_q.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (checked_count < total_items)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
